@@ rtl/core/tdc_pkg.sv @@
// tdc_pkg: shared widths, reset values and codes for the tilt direction classifier
// no dependencies; imported by tilt_direction_classifier
package tdc_pkg;

  localparam int DATA_W      = 16;
  localparam int THR_W       = 15;
  localparam int DIR_W       = 3;
  localparam int CFG_IDX_W   = 1;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  localparam int HIST_DEPTH_DEF = 4;

  localparam logic [THR_W-1:0] HIGH_THR_RST = 15'd550;
  localparam logic [THR_W-1:0] LOW_THR_RST  = 15'd450;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 1'b1;

  // direction codes
  localparam logic [DIR_W-1:0] DIR_NONE  = 3'd0;
  localparam logic [DIR_W-1:0] DIR_UP    = 3'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN  = 3'd2;
  localparam logic [DIR_W-1:0] DIR_LEFT  = 3'd3;
  localparam logic [DIR_W-1:0] DIR_RIGHT = 3'd4;

endpackage

@@ rtl/core/tilt_direction_classifier.sv @@
// tilt_direction_classifier: moving average of x/y rate samples and tilt classification
// depends on tdc_pkg for widths, reset values, register indexes and direction codes
//
// Takes one x/y sample pair per transfer and returns one result per pair: the means
// of the last HISTORY_DEPTH samples of each axis (signed, truncated toward zero), a
// direction (none, up, down, left, right) and a flag set when the direction differs
// from the previous one. A strong y tilt (at or above the high threshold) picks up or
// down, a strong x tilt on top of it wins only with the larger magnitude; with no
// strong y tilt both means below the low threshold clear the direction to none, and
// anything else holds the last one. The block takes a new pair every cycle unless
// out_tready holds the pipeline; out_tvalid rises once a pair has passed the running
// sum, updated at the transfer itself, then the reciprocal multiply, the mean and the
// classified output register. The single running-sum update per axis paces the input
// at one pair per cycle. Both rings and sums start at zero after reset. Thresholds
// should only be written while no pair is in flight.
module tilt_direction_classifier
  import tdc_pkg::*;
#(
  parameter int HISTORY_DEPTH = HIST_DEPTH_DEF   // 2 to 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // sample input: [15:0] x_sample, [31:16] y_sample
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // result output: [15:0] x_mean, [31:16] y_mean, [34:32] direction,
  // [35] direction_changed, [39:36] zero
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // threshold write port
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_idx,
  input  logic [THR_W-1:0]       cfg_wdata
);

  // ring sum width and reciprocal for the exact divide by depth
  localparam int SLOT_W = $clog2(HISTORY_DEPTH);
  localparam int SUM_W  = DATA_W + SLOT_W;
  localparam int RCP_SH = SUM_W + SLOT_W;
  localparam int RCP_W  = SUM_W + 2;
  localparam int PROD_W = SUM_W + RCP_W;
  localparam longint unsigned RCP_L =
    ((64'd1 << RCP_SH) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
  localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_L);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(HISTORY_DEPTH - 1);

  // thresholds
  logic [THR_W-1:0] high_thr_r;
  logic [THR_W-1:0] low_thr_r;

  // history rings, axis 0 is x, axis 1 is y
  logic signed [DATA_W-1:0] ring_r [2][HISTORY_DEPTH];
  logic [SLOT_W-1:0]        slot_r;
  logic [SLOT_W-1:0]        slot_nxt;

  // stage 0: running sums, always the sums of the rings after the last write
  logic                     v0_r;
  logic signed [SUM_W-1:0]  acc_r [2];
  logic signed [SUM_W-1:0]  acc_nxt [2];

  // stage 1: magnitude times reciprocal, sign kept aside
  logic                     v1_r;
  logic [PROD_W-1:0]        prod_r [2];
  logic                     neg_r [2];
  logic [SUM_W-1:0]         mag [2];

  // stage 2: means
  logic                     v2_r;
  logic signed [DATA_W-1:0] mean_r [2];
  logic [DATA_W-1:0]        quo [2];

  // output register and held selection
  logic                     out_tvalid_r;
  logic signed [DATA_W-1:0] out_x_r;
  logic signed [DATA_W-1:0] out_y_r;
  logic [DIR_W-1:0]         out_dir_r;
  logic                     out_chg_r;
  logic [DIR_W-1:0]         last_dir_r;
  logic [DIR_W-1:0]         dir_nxt;

  // stage enables, each stage loads when empty or when it moves on
  logic en_out;
  logic en2;
  logic en1;
  logic en0;
  logic in_xfer;

  assign en_out  = !out_tvalid_r || out_tready;
  assign en2     = !v2_r || en_out;
  assign en1     = !v1_r || en2;
  assign en0     = !v0_r || en1;
  assign in_xfer = in_tvalid && en0;

  assign in_tready  = en0;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'd0, out_chg_r, out_dir_r, out_y_r, out_x_r};

  // tilt rules: strong y first, x only wins with the larger magnitude
  function automatic logic [DIR_W-1:0] classify(
    input logic signed [DATA_W-1:0] xm,
    input logic signed [DATA_W-1:0] ym,
    input logic [THR_W-1:0]         hi,
    input logic [THR_W-1:0]         lo,
    input logic [DIR_W-1:0]         last
  );
    logic signed [DATA_W+1:0] x;
    logic signed [DATA_W+1:0] y;
    logic signed [DATA_W+1:0] h;
    logic signed [DATA_W+1:0] l;
    logic signed [DATA_W+1:0] ax;
    logic signed [DATA_W+1:0] ay;
    logic [DIR_W-1:0]         d;
    x  = {{2{xm[DATA_W-1]}}, xm};
    y  = {{2{ym[DATA_W-1]}}, ym};
    h  = {3'd0, hi};
    l  = {3'd0, lo};
    ax = x[DATA_W+1] ? -x : x;
    ay = y[DATA_W+1] ? -y : y;
    if (y >= h) begin
      if (x >= h)
        d = (x > y) ? DIR_RIGHT : DIR_UP;
      else if (x <= -h)
        d = (ax > y) ? DIR_LEFT : DIR_UP;
      else
        d = DIR_UP;
    end else if (y <= -h) begin
      if (x <= -h)
        d = (ax > ay) ? DIR_LEFT : DIR_DOWN;
      else if (x >= h)
        d = (x > ay) ? DIR_RIGHT : DIR_DOWN;
      else
        d = DIR_DOWN;
    end else if (ax < l && ay < l) begin
      d = DIR_NONE;
    end else begin
      d = last;
    end
    return d;
  endfunction

  // running sum: drop the sample being overwritten, add the new one
  always_comb begin
    slot_nxt   = (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
    acc_nxt[0] = acc_r[0] - SUM_W'(ring_r[0][slot_r])
               + SUM_W'($signed(in_tdata[DATA_W-1:0]));
    acc_nxt[1] = acc_r[1] - SUM_W'(ring_r[1][slot_r])
               + SUM_W'($signed(in_tdata[2*DATA_W-1:DATA_W]));
  end

  // magnitudes of the sums and quotients of the products
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      mag[a] = acc_r[a][SUM_W-1] ? SUM_W'(-acc_r[a]) : SUM_W'(acc_r[a]);
      quo[a] = prod_r[a][RCP_SH +: DATA_W];
    end
  end

  assign dir_nxt = classify(mean_r[0], mean_r[1], high_thr_r, low_thr_r, last_dir_r);

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r <= HIGH_THR_RST;
      low_thr_r  <= LOW_THR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_HIGH_THR: high_thr_r <= cfg_wdata;
        REG_LOW_THR:  low_thr_r  <= cfg_wdata;
        default:      ;
      endcase
    end
  end

  // rings, slot pointer and running sums
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
      v0_r   <= 1'b0;
      for (int a = 0; a < 2; a++) begin
        acc_r[a] <= '0;
        for (int i = 0; i < HISTORY_DEPTH; i++)
          ring_r[a][i] <= '0;
      end
    end else begin
      if (en0)
        v0_r <= in_tvalid;
      if (in_xfer) begin
        slot_r            <= slot_nxt;
        acc_r[0]          <= acc_nxt[0];
        acc_r[1]          <= acc_nxt[1];
        ring_r[0][slot_r] <= $signed(in_tdata[DATA_W-1:0]);
        ring_r[1][slot_r] <= $signed(in_tdata[2*DATA_W-1:DATA_W]);
      end
    end
  end

  // reciprocal multiply and mean stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1)
        v1_r <= v0_r;
      if (en2)
        v2_r <= v1_r;
    end
    if (en1) begin
      for (int a = 0; a < 2; a++) begin
        prod_r[a] <= PROD_W'(mag[a]) * PROD_W'(RCP);
        neg_r[a]  <= acc_r[a][SUM_W-1];
      end
    end
    if (en2) begin
      for (int a = 0; a < 2; a++)
        mean_r[a] <= neg_r[a] ? -$signed(quo[a]) : $signed(quo[a]);
    end
  end

  // classification into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
      last_dir_r   <= DIR_NONE;
    end else if (en_out) begin
      out_tvalid_r <= v2_r;
      if (v2_r)
        last_dir_r <= dir_nxt;
    end
    if (en_out && v2_r) begin
      out_x_r   <= mean_r[0];
      out_y_r   <= mean_r[1];
      out_dir_r <= dir_nxt;
      out_chg_r <= (dir_nxt != last_dir_r);
    end
  end

endmodule
